>>> rtl/core/dws_pkg.sv
// shared types, constants and helpers of the display write sequencer
package dws_pkg;

  localparam int CoordBits = 10;
  localparam int PanelW    = (CoordBits > 12) ? CoordBits : 12;
  localparam int FifoDepth = 4;
  localparam int QPtrW     = $clog2(FifoDepth);
  localparam int QCntW     = $clog2(FifoDepth + 1);
  localparam int NumSlots  = 8;
  localparam int SlotW     = $clog2(NumSlots);
  localparam int InDataW   = 64;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 10;

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic [1:0] {
    ActPixel  = 2'd0,
    ActWindow = 2'd1,
    ActStream = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegScreenWidth  = 3'd0,
    RegScreenHeight = 3'd1,
    RegColumnOffset = 3'd2,
    RegRowOffset    = 3'd3,
    RegColumnSetOp  = 3'd4,
    RegRowSetOp     = 3'd5,
    RegMemWriteOp   = 3'd6
  } cfg_idx_e;

  // transfer slots in the order they go out
  typedef enum logic [SlotW-1:0] {
    SlotColCmd = 3'd0,
    SlotColLo  = 3'd1,
    SlotColHi  = 3'd2,
    SlotRowCmd = 3'd3,
    SlotRowLo  = 3'd4,
    SlotRowHi  = 3'd5,
    SlotMemCmd = 3'd6,
    SlotColor  = 3'd7
  } slot_e;

  typedef struct packed {
    logic [9:0] screen_width;
    logic [9:0] screen_height;
    logic [8:0] column_offset;
    logic [8:0] row_offset;
    logic [7:0] column_set_op;
    logic [7:0] row_set_op;
    logic [7:0] mem_write_op;
  } cfg_t;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    coord_t              col_lo;
    coord_t              col_hi;
    coord_t              row_lo;
    coord_t              row_hi;
    logic [15:0]         color;
  } job_t;

  // panel coordinate: position plus offset, wrapped to the coordinate width
  function automatic coord_t panel_f(logic [9:0] pos, logic [8:0] off);
    logic [PanelW-1:0] sum;
    sum = PanelW'(pos) + PanelW'(off);
    return sum[CoordBits-1:0];
  endfunction

endpackage

>>> rtl/core/display_write_sequencer.sv
// top level: configuration registers, front end, job queue and transfer sequencer
// path: a taken request goes into the job queue, then the job register and slot mask, then
//   the output register; transfers follow one per cycle while the output is ready
// throughput: one color-word request per cycle while the output is ready;
//   pixel requests give 2, 5 or 8 transfers, windows 7, through the single output register
// reset: address cache invalid, job queue empty, registers at their documented values
module display_write_sequencer import dws_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // pos_x, pos_y, rect_width, rect_height, color
  input  logic [1:0]          s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // value
  output logic [1:0]          m_axis_tuser,  // cmd_flag, is_word
  output logic                m_axis_tlast
);

  cfg_t cfg_q;
  logic push, pop, q_valid, q_full;
  job_t job_in, job_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 10'd240;
      cfg_q.screen_height <= 10'd320;
      cfg_q.column_offset <= 9'd0;
      cfg_q.row_offset    <= 9'd0;
      cfg_q.column_set_op <= 8'd42;
      cfg_q.row_set_op    <= 8'd43;
      cfg_q.mem_write_op  <= 8'd44;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegScreenWidth:  cfg_q.screen_width  <= cfg_wdata_i;
        RegScreenHeight: cfg_q.screen_height <= cfg_wdata_i;
        RegColumnOffset: cfg_q.column_offset <= cfg_wdata_i[8:0];
        RegRowOffset:    cfg_q.row_offset    <= cfg_wdata_i[8:0];
        RegColumnSetOp:  cfg_q.column_set_op <= cfg_wdata_i[7:0];
        RegRowSetOp:     cfg_q.row_set_op    <= cfg_wdata_i[7:0];
        RegMemWriteOp:   cfg_q.mem_write_op  <= cfg_wdata_i[7:0];
        default:         cfg_q               <= cfg_q;
      endcase
    end
  end

  dws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (job_in)
  );

  dws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (job_head)
  );

  dws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (q_valid),
    .job_i         (job_head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("job queue written while full");

  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("job queue read while empty");

  a_cmd_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[15:8] == 8'h00 && !m_axis_tuser[1]))
    else $error("command transfer with upper bits set or word flag");

endmodule

>>> rtl/core/dws_front.sv
// front end: accepts requests, clips them, checks the address cache, builds jobs
module dws_front import dws_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // pos_x, pos_y, rect_width, rect_height, color
  input  logic [1:0]         s_axis_tuser,  // action
  input  logic               q_full_i,
  output logic               push_o,
  output job_t               job_o
);

  logic signed [10:0] pos_x, pos_y, rect_w, rect_h;
  logic        [15:0] color;
  logic signed [11:0] x12, y12, sw12, sh12, end_x, end_y, clip_ex, clip_ey, start_x, start_y;
  logic signed [11:0] hi_x, hi_y;
  logic               x_off, y_off, on_screen, win_ok, accept;
  coord_t             px, py;
  logic               col_hit, row_hit;

  coord_t cached_col_q, cached_col_d, cached_row_q, cached_row_d;
  logic   col_known_q, col_known_d, row_known_q, row_known_d;

  assign pos_x  = s_axis_tdata[10:0];
  assign pos_y  = s_axis_tdata[21:11];
  assign rect_w = s_axis_tdata[32:22];
  assign rect_h = s_axis_tdata[43:33];
  assign color  = s_axis_tdata[59:44];

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign x12  = 12'(pos_x);
  assign y12  = 12'(pos_y);
  assign sw12 = $signed({2'b00, cfg_i.screen_width});
  assign sh12 = $signed({2'b00, cfg_i.screen_height});

  assign x_off     = x12 >= sw12;
  assign y_off     = y12 >= sh12;
  assign on_screen = !pos_x[10] && !pos_y[10] && !x_off && !y_off;

  // clipped window as [start, end): end is x+w cut at the screen edge
  assign end_x   = x12 + 12'(rect_w);
  assign end_y   = y12 + 12'(rect_h);
  assign clip_ex = (end_x > sw12) ? sw12 : end_x;
  assign clip_ey = (end_y > sh12) ? sh12 : end_y;
  assign start_x = pos_x[10] ? 12'sd0 : x12;
  assign start_y = pos_y[10] ? 12'sd0 : y12;
  assign hi_x    = clip_ex - 12'sd1;
  assign hi_y    = clip_ey - 12'sd1;
  assign win_ok  = !x_off && !y_off && (clip_ex > start_x) && (clip_ey > start_y);

  assign px      = panel_f(pos_x[9:0], cfg_i.column_offset);
  assign py      = panel_f(pos_y[9:0], cfg_i.row_offset);
  assign col_hit = col_known_q && (cached_col_q == px);
  assign row_hit = row_known_q && (cached_row_q == py);

  always_comb begin
    job_o        = '0;
    job_o.color  = color;
    cached_col_d = cached_col_q;
    cached_row_d = cached_row_q;
    col_known_d  = col_known_q;
    row_known_d  = row_known_q;
    case (s_axis_tuser)
      ActPixel: begin
        job_o.col_lo = px;
        job_o.col_hi = px;
        job_o.row_lo = py;
        job_o.row_hi = py;
        if (on_screen) begin
          job_o.mask[SlotMemCmd] = 1'b1;
          job_o.mask[SlotColor]  = 1'b1;
          if (!col_hit) begin
            job_o.mask[SlotColCmd] = 1'b1;
            job_o.mask[SlotColLo]  = 1'b1;
            job_o.mask[SlotColHi]  = 1'b1;
            cached_col_d           = px;
            col_known_d            = 1'b1;
          end
          if (!row_hit) begin
            job_o.mask[SlotRowCmd] = 1'b1;
            job_o.mask[SlotRowLo]  = 1'b1;
            job_o.mask[SlotRowHi]  = 1'b1;
            cached_row_d           = py;
            row_known_d            = 1'b1;
          end
        end
      end
      ActWindow: begin
        job_o.col_lo = panel_f(start_x[9:0], cfg_i.column_offset);
        job_o.col_hi = panel_f(hi_x[9:0], cfg_i.column_offset);
        job_o.row_lo = panel_f(start_y[9:0], cfg_i.row_offset);
        job_o.row_hi = panel_f(hi_y[9:0], cfg_i.row_offset);
        if (win_ok) begin
          job_o.mask[SlotColCmd] = 1'b1;
          job_o.mask[SlotColLo]  = 1'b1;
          job_o.mask[SlotColHi]  = 1'b1;
          job_o.mask[SlotRowCmd] = 1'b1;
          job_o.mask[SlotRowLo]  = 1'b1;
          job_o.mask[SlotRowHi]  = 1'b1;
          job_o.mask[SlotMemCmd] = 1'b1;
          col_known_d            = 1'b0;
          row_known_d            = 1'b0;
        end
      end
      ActStream: begin
        job_o.mask[SlotColor] = 1'b1;
      end
      default: begin
        job_o.mask = '0;
      end
    endcase
  end

  assign push_o = accept && (job_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_col_q <= '0;
      cached_row_q <= '0;
      col_known_q  <= 1'b0;
      row_known_q  <= 1'b0;
    end else if (accept) begin
      cached_col_q <= cached_col_d;
      cached_row_q <= cached_row_d;
      col_known_q  <= col_known_d;
      row_known_q  <= row_known_d;
    end
  end

endmodule

>>> rtl/core/dws_queue.sv
// short job queue between front end and transfer sequencer
module dws_queue import dws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t head_o
);

  job_t             mem_q [FifoDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == QCntW'(FifoDepth);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/dws_back.sv
// back end: walks job slots, one transfer per cycle while output is ready
module dws_back import dws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // value
  output logic [1:0]  m_axis_tuser,  // cmd_flag, is_word
  output logic        m_axis_tlast
);

  logic [NumSlots-1:0] mask_q, mask_d, slot_oh, remaining;
  job_t                cur_q;
  slot_e               slot;
  logic                adv, emit, done, load;
  logic                cmd;
  logic [15:0]         value;

  logic                out_valid_q;
  logic                out_cmd_q, out_last_q;
  logic [15:0]         out_value_q;

  // lowest pending slot goes next
  always_comb begin
    slot = SlotColor;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = slot_e'(SlotW'(i));
      end
    end
  end

  assign slot_oh   = NumSlots'(1) << slot;
  assign remaining = mask_q & ~slot_oh;

  assign adv   = !out_valid_q || m_axis_tready;
  assign emit  = (mask_q != '0) && adv;
  assign done  = (mask_q == '0) || (emit && (remaining == '0));
  assign load  = done && job_valid_i;
  assign pop_o = load;

  always_comb begin
    mask_d = mask_q;
    if (emit) begin
      mask_d = remaining;
    end
    if (load) begin
      mask_d = job_i.mask;
    end
  end

  always_comb begin
    cmd   = 1'b0;
    value = cur_q.color;
    case (slot)
      SlotColCmd: begin
        cmd   = 1'b1;
        value = {8'h00, cfg_i.column_set_op};
      end
      SlotColLo:  value = 16'(cur_q.col_lo);
      SlotColHi:  value = 16'(cur_q.col_hi);
      SlotRowCmd: begin
        cmd   = 1'b1;
        value = {8'h00, cfg_i.row_set_op};
      end
      SlotRowLo:  value = 16'(cur_q.row_lo);
      SlotRowHi:  value = 16'(cur_q.row_hi);
      SlotMemCmd: begin
        cmd   = 1'b1;
        value = {8'h00, cfg_i.mem_write_op};
      end
      SlotColor:  value = cur_q.color;
      default:    value = cur_q.color;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
    end
    if (emit) begin
      out_cmd_q   <= cmd;
      out_last_q  <= remaining == '0;
      out_value_q <= value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {!out_cmd_q, out_cmd_q};
  assign m_axis_tlast  = out_last_q;

endmodule
